// ===== rtl/wed_pkg.sv =====
package wed_pkg;

    // Fixed field widths
    localparam int PIX_W  = 8;
    localparam int DIM_W  = 11;
    localparam int MASK_W = 49;

    // Structuring element grid, always 7x7 with the origin in the middle
    localparam int GRID   = 7;
    localparam int CENTER = 3;

    // Result queue depth
    localparam int OUT_DEPTH = 8;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_WINDOW_SIZE = 7;

    localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;
    localparam logic [PIX_W-1:0]  THRESHOLD  = 8'd128;
    localparam logic [MASK_W-1:0] MASK_RST   = 49'h0_0001_C387_0000;
    localparam logic [DIM_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RST = 11'd480;

    typedef enum logic [1:0] {
        REG_DILATE_MODE  = 2'd0,
        REG_SHAPE_MASK   = 2'd1,
        REG_FRAME_WIDTH  = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } cfg_reg_t;

    // One finished result on its way to the output
    typedef struct packed {
        logic on;
        logic last;
    } res_t;

    // min for erode, max for dilate
    function automatic logic [PIX_W-1:0] pick(input logic dil,
                                              input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic a_wins;
        a_wins = dil ? (a > b) : (a < b);
        return a_wins ? a : b;
    endfunction

endpackage

// ===== rtl/wed_line.sv =====
module wed_line
    import wed_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    waddr,
    input  logic [AW-1:0]    raddr,
    input  logic [PIX_W-1:0] din,
    output logic [PIX_W-1:0] dout
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] dout_reg;

    // Write lags the read by one column; forward when both hit the same
    // column (one-pixel rows).
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mem[waddr] <= din;
            if (waddr == raddr)
                dout_reg <= din;
            else
                dout_reg <= mem[raddr];
        end
    end

    assign dout = dout_reg;

endmodule

// ===== rtl/wed_cell.sv =====
module wed_cell
    import wed_pkg::*;
(
    input  logic             clk,
    input  logic             shift,
    input  logic [PIX_W-1:0] din,
    input  logic             take,
    input  logic [PIX_W-1:0] border,
    output logic [PIX_W-1:0] pix,
    output logic [PIX_W-1:0] val
);

    logic [PIX_W-1:0] pix_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
            pix_reg <= din;
    end

    assign pix = pix_reg;
    // Masked-off or off-frame positions contribute the neutral value
    assign val = take ? pix_reg : border;

endmodule

// ===== rtl/wed_ofifo.sv =====
module wed_ofifo
    import wed_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    input  logic pop_ready,
    output logic out_valid,
    output res_t out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/window_erode_dilate_filter.sv =====
// A result passes the stage 1 to 3 registers and the result queue before it is offered on the master side.
// Throughput: one request per cycle; the SPAN-1 (6) line stores are read in parallel, and
//   the slave side stalls only while OUT_DEPTH (8) results are accepted but not yet taken on the master side.
// Output lags input by HALF rows plus HALF pixels; flush requests push the tail out.
// Reset: asynchronous, active low; clears counters and the result queue, loads config defaults.
// Line stores need no clearing pass; their contents are masked until written.
module window_erode_dilate_filter
    import wed_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
)
(
    input  logic              clk,
    input  logic              rst_n,

    // Configuration write port
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [MASK_W-1:0] cfg_wdata,

    // Pixel requests in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] pixel_in
    input  logic              s_axis_tuser,   // [0] req_type (1 = flush)

    // Results out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] pixel_on, [7:1] zero
    output logic              m_axis_tlast    // frame_last
);

    // ------------------------------------------------------------------
    // Geometry
    // ------------------------------------------------------------------
    localparam int HALF   = WINDOW_SIZE / 2;
    localparam int SPAN   = 2 * HALF + 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int MW_W   = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = ((MW_W > DIM_W) ? MW_W : DIM_W) + 1;
    localparam int LAG_W  = $clog2(HALF * MAX_WIDTH + HALF + 1);
    localparam int PEND_W = $clog2(OUT_DEPTH + 1);

    localparam int W_RST_INT = (int'(WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH : int'(WIDTH_RST);
    localparam logic [DIM_W-1:0] W_RST   = DIM_W'(W_RST_INT);
    localparam logic [LAG_W-1:0] LAG_RST = LAG_W'(HALF * W_RST_INT + HALF);

    typedef struct packed {
        logic             last;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } pos_t;

    // ------------------------------------------------------------------
    // Configuration registers. Width and height are clamped at write time,
    // and the start-up lag (HALF rows + HALF pixels) is precomputed.
    // ------------------------------------------------------------------
    logic              mode_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [DIM_W-1:0]  w_reg;
    logic [DIM_W-1:0]  h_reg;
    logic [LAG_W-1:0]  lag_reg;

    logic [DIM_W-1:0]  wr_dim;
    logic [DIM_W-1:0]  w_clamp;
    logic [DIM_W-1:0]  h_clamp;
    logic [LAG_W-1:0]  lag_calc;

    assign wr_dim = cfg_wdata[DIM_W-1:0];

    always_comb
    begin
        if (wr_dim == '0)
            w_clamp = DIM_W'(1);
        else if (CMP_W'(wr_dim) > CMP_W'(MAX_WIDTH))
            w_clamp = DIM_W'(MAX_WIDTH);
        else
            w_clamp = wr_dim;
        h_clamp  = (wr_dim == '0) ? DIM_W'(1) : wr_dim;
        lag_calc = LAG_W'(w_clamp) * LAG_W'(HALF) + LAG_W'(HALF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            mask_reg <= MASK_RST;
            w_reg    <= W_RST;
            h_reg    <= HEIGHT_RST;
            lag_reg  <= LAG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_DILATE_MODE:  mode_reg <= cfg_wdata[0];
                REG_SHAPE_MASK:   mask_reg <= cfg_wdata;
                REG_FRAME_WIDTH:
                begin
                    w_reg   <= w_clamp;
                    lag_reg <= lag_calc;
                end
                REG_FRAME_HEIGHT: h_reg <= h_clamp;
                default: ;
            endcase
        end
    end

    logic [PIX_W-1:0] border;
    assign border = mode_reg ? '0 : PIX_MAX;

    // ------------------------------------------------------------------
    // Raster position tracking
    //   pre_reg counts requests of the frame until the lag is covered;
    //   from then on every request releases one output position.
    // ------------------------------------------------------------------
    logic              in_acc;
    logic              pop;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic [LAG_W-1:0]  pre_reg, pre_next, base_pre;
    logic [COL_W-1:0]  in_col_reg, in_col_next, base_col;
    logic [DIM_W-1:0]  out_col_reg, out_col_next, base_ocol;
    logic [DIM_W-1:0]  out_row_reg, out_row_next, base_orow;
    logic              frame_over;
    logic              produce;
    logic              is_last;
    logic [COL_W-1:0]  col_inc;
    logic [DIM_W-1:0]  ocol_inc;

    assign s_axis_tready = (pend_reg < PEND_W'(OUT_DEPTH));
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    // Height shrunk below the current output row: start over
    assign frame_over = (out_row_reg >= h_reg);
    assign base_pre   = frame_over ? '0 : pre_reg;
    assign base_col   = frame_over ? '0 : in_col_reg;
    assign base_ocol  = frame_over ? '0 : out_col_reg;
    assign base_orow  = frame_over ? '0 : out_row_reg;

    assign produce  = (base_pre == lag_reg);
    assign is_last  = produce && (base_ocol == w_reg - 1'b1) && (base_orow == h_reg - 1'b1);
    assign col_inc  = base_col + 1'b1;
    assign ocol_inc = base_ocol + 1'b1;

    always_comb
    begin
        pre_next     = pre_reg;
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (in_acc)
        begin
            if (is_last)
            begin
                pre_next     = '0;
                in_col_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                pre_next = produce ? base_pre : base_pre + 1'b1;
                if (CMP_W'(base_col) + CMP_W'(1) >= CMP_W'(w_reg))
                    in_col_next = '0;
                else
                    in_col_next = col_inc;
                out_col_next = base_ocol;
                out_row_next = base_orow;
                if (produce)
                begin
                    if (ocol_inc >= w_reg)
                    begin
                        out_col_next = '0;
                        out_row_next = base_orow + 1'b1;
                    end
                    else
                    begin
                        out_col_next = ocol_inc;
                    end
                end
            end
        end
    end

    // Results accepted but not yet taken; keeps the queue from overflowing
    always_comb
    begin
        pend_next = pend_reg;
        if ((in_acc && produce) && !pop)
            pend_next = pend_reg + 1'b1;
        else if (!(in_acc && produce) && pop)
            pend_next = pend_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg     <= '0;
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            pre_reg     <= pre_next;
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: request registered; line stores read at its column.
    // After this edge p_reg and line_q[] hold one full window column.
    // ------------------------------------------------------------------
    logic             v1_reg;
    logic             prod1_reg;
    pos_t             pos1_reg;
    logic [PIX_W-1:0] p_reg;
    logic [COL_W-1:0] col_reg;
    logic [PIX_W-1:0] line_q [SPAN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            prod1_reg <= 1'b0;
            col_reg   <= '0;
        end
        else
        begin
            v1_reg <= in_acc;
            if (in_acc)
            begin
                prod1_reg <= produce;
                col_reg   <= base_col;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p_reg    <= s_axis_tuser ? '0 : s_axis_tdata;
            pos1_reg <= '{last: is_last, row: base_orow, col: base_ocol};
        end
    end

    // Cascade of line stores: each delays the column stream by one row
    genvar gk;
    generate
        for (gk = 0; gk < SPAN - 1; gk++)
        begin : g_line
            wed_line #(
                .DEPTH (MAX_WIDTH)
            ) u_line (
                .clk   (clk),
                .en    (in_acc),
                .waddr (col_reg),
                .raddr (base_col),
                .din   ((gk == 0) ? p_reg : line_q[(gk == 0) ? 0 : gk - 1]),
                .dout  (line_q[gk])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 2: window of SPAN x SPAN cells; each cell hands its pixel to
    // its left neighbor, the right column loads the fresh column.
    // Row / column in-frame flags are registered alongside.
    // ------------------------------------------------------------------
    logic             v2_reg;
    logic             last2_reg;
    logic [SPAN-1:0]  row_ok, row_ok_reg;
    logic [SPAN-1:0]  col_ok, col_ok_reg;
    logic [PIX_W-1:0] col_in   [SPAN];
    logic [PIX_W-1:0] cell_pix [SPAN][SPAN];
    logic [PIX_W-1:0] cell_val [SPAN][SPAN];

    always_comb
    begin
        for (int i = 0; i < SPAN; i++)
        begin
            row_ok[i] = (CMP_W'(pos1_reg.row) + CMP_W'(i) >= CMP_W'(HALF)) &&
                        (CMP_W'(pos1_reg.row) + CMP_W'(i) < CMP_W'(h_reg) + CMP_W'(HALF));
            col_ok[i] = (CMP_W'(pos1_reg.col) + CMP_W'(i) >= CMP_W'(HALF)) &&
                        (CMP_W'(pos1_reg.col) + CMP_W'(i) < CMP_W'(w_reg) + CMP_W'(HALF));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg & prod1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            last2_reg  <= pos1_reg.last;
            row_ok_reg <= row_ok;
            col_ok_reg <= col_ok;
        end
    end

    // Bottom row is the newest line, rows above come from the line stores
    always_comb
    begin
        col_in[SPAN-1] = p_reg;
        for (int i = 0; i < SPAN - 1; i++)
            col_in[i] = line_q[SPAN-2-i];
    end

    genvar gi, gj;
    generate
        for (gi = 0; gi < SPAN; gi++)
        begin : g_row
            for (gj = 0; gj < SPAN; gj++)
            begin : g_col
                localparam int SLOT = (gi + CENTER - HALF) * GRID + (gj + CENTER - HALF);
                wed_cell u_cell (
                    .clk    (clk),
                    .shift  (v1_reg),
                    .din    ((gj == SPAN - 1) ? col_in[gi]
                                              : cell_pix[gi][(gj == SPAN - 1) ? gj : gj + 1]),
                    .take   (mask_reg[SLOT] & row_ok_reg[gi] & col_ok_reg[gj]),
                    .border (border),
                    .pix    (cell_pix[gi][gj]),
                    .val    (cell_val[gi][gj])
                );
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 3: per-row min / max
    // ------------------------------------------------------------------
    logic             v3_reg;
    logic             last3_reg;
    logic [PIX_W-1:0] row_acc [SPAN];
    logic [PIX_W-1:0] row_red_reg [SPAN];

    always_comb
    begin
        for (int i = 0; i < SPAN; i++)
        begin
            row_acc[i] = cell_val[i][0];
            for (int j = 1; j < SPAN; j++)
                row_acc[i] = pick(mode_reg, row_acc[i], cell_val[i][j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            last3_reg <= last2_reg;
            for (int i = 0; i < SPAN; i++)
                row_red_reg[i] <= row_acc[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: fold the rows, threshold, queue the result
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] fin;
    res_t             res;
    res_t             q_res;

    always_comb
    begin
        fin = row_red_reg[0];
        for (int i = 1; i < SPAN; i++)
            fin = pick(mode_reg, fin, row_red_reg[i]);
        res.on   = (fin > THRESHOLD);
        res.last = last3_reg;
    end

    wed_ofifo #(
        .DEPTH (OUT_DEPTH)
    ) u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (v3_reg),
        .push_data (res),
        .pop_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (q_res)
    );

    assign pop          = m_axis_tvalid & m_axis_tready;
    assign m_axis_tdata = {7'b0, q_res.on};
    assign m_axis_tlast = q_res.last;

endmodule
